FILE: src/buddy_page_allocator_assert.svh
// Assertion macros for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define BPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpa check failed");

// Next-cycle implication, checked on clk, off during reset.
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpa check failed");

`endif

FILE: src/bpa_pkg.sv
// Package: sizes, entry and port-request types, and helper functions of the allocator.
package bpa_pkg;

    localparam int POOL_PAGES = 1024;
    localparam int NUM_ORDERS = 11;
    localparam int PAGE_BYTES = 4096;

    localparam int PAGE_W = $clog2(POOL_PAGES);
    localparam int LINK_W = $clog2(POOL_PAGES + 1);
    localparam int ORD_W  = $clog2(NUM_ORDERS);
    localparam int ORDC_W = $clog2(NUM_ORDERS + 1);
    localparam int WIDE_W = ((PAGE_W > NUM_ORDERS) ? PAGE_W : NUM_ORDERS) + 1;
    localparam int REQ_W  = 24;

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(POOL_PAGES);
    localparam logic [ORD_W-1:0]  TOP_ORDER = ORD_W'(NUM_ORDERS - 1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // One word of the block table
    typedef struct packed {
        logic [ORD_W-1:0]  order;
        logic              is_free;
        logic [LINK_W-1:0] link;
    } bpa_entry_t;

    typedef struct packed {
        logic             we;
        logic [PAGE_W-1:0] addr;
        bpa_entry_t       data;
    } bpa_wr_t;

    typedef struct packed {
        logic             re;
        logic [PAGE_W-1:0] addr;
    } bpa_rd_t;

    // Smallest order whose block holds req bytes; NUM_ORDERS when none does
    function automatic logic [ORDC_W-1:0] req_order(input logic [REQ_W-1:0] req);
        logic [ORDC_W-1:0] cnt;
        logic [47:0]       sz;
        cnt = '0;
        for (int k = 0; k < NUM_ORDERS; k++) begin
            sz = 48'(PAGE_BYTES) << k;
            if (sz < 48'(req)) begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt;
    endfunction

    // Largest aligned order that fits inside the pool at this page
    function automatic logic [ORD_W-1:0] init_order(input logic [PAGE_W-1:0] addr);
        logic [ORD_W-1:0]  ord;
        logic [WIDE_W-1:0] sz;
        ord = '0;
        for (int k = 1; k < NUM_ORDERS; k++) begin
            sz = WIDE_W'(1) << k;
            if (((WIDE_W'(addr) & (sz - 1'b1)) == '0) &&
                (WIDE_W'(addr) + sz <= WIDE_W'(POOL_PAGES))) begin
                ord = ORD_W'(k);
            end
        end
        return ord;
    endfunction

endpackage

FILE: src/bpa_mem.sv
// Block table memory: one write port, one registered read port.
module bpa_mem
    import bpa_pkg::*;
(
    input  logic       clk,
    input  bpa_wr_t    wr,
    input  bpa_rd_t    rd,
    output bpa_entry_t rd_data
);

    bpa_entry_t mem [POOL_PAGES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

FILE: src/buddy_page_allocator.sv
// Buddy page allocator: command sequencer over the block table memory.
// Alloc searches the lists from the requested order up, then splits down; free reads each
//   buddy, walks its list to unlink it and merges up while the buddy is free, below the
//   top order and inside the pool. One command at a time, no overlap.
// Busy drops in the done cycle; done stands one cycle, the receiver cannot stall.
// Reset clears the lists, then a sweep over every page carves the pool; busy stays high.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [REQ_W-1:0]  req_bytes,
    input  logic [PAGE_W-1:0] page_in,
    output logic              done,
    output logic [PAGE_W-1:0] page_out,
    output logic              status,
    output logic [LINK_W-1:0] free_pages
);

`include "buddy_page_allocator_assert.svh"

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ASRCH, S_APOP, S_ASPLIT, S_AFIN,
        S_FCHK, S_FBUD, S_FBCHK, S_WALK, S_WCHK, S_UNL, S_FPUSH
    } state_t;

    state_t            state_reg, state_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [ORD_W-1:0]  lvl_reg, lvl_next;
    logic [ORD_W-1:0]  orig_reg, orig_next;
    logic [PAGE_W-1:0] blk_reg, blk_next;
    logic [PAGE_W-1:0] addr_reg, addr_next;
    logic [PAGE_W-1:0] buddy_reg, buddy_next;
    bpa_entry_t        bword_reg, bword_next;
    bpa_entry_t        pword_reg, pword_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [WIDE_W-1:0] steps_reg, steps_next;
    logic [LINK_W-1:0] count_reg, count_next;
    logic [PAGE_W-1:0] init_idx_reg, init_idx_next;
    logic [WIDE_W-1:0] head_nx_reg, head_nx_next;
    logic [LINK_W-1:0] list_head_reg [NUM_ORDERS];
    logic [LINK_W-1:0] list_head_next [NUM_ORDERS];
    logic              done_reg, done_next;
    logic [PAGE_W-1:0] page_out_reg, page_out_next;
    logic              status_reg, status_next;

    bpa_wr_t    wr;
    bpa_rd_t    rd;
    bpa_entry_t rd_data;

    logic [ORDC_W-1:0] req_ord;
    logic [ORD_W-1:0]  init_k;
    logic [WIDE_W-1:0] lvl_pow;
    logic [WIDE_W-1:0] half_page;
    logic [WIDE_W-1:0] buddy_wide;
    logic [WIDE_W+1:0] cnt_sum;
    logic [WIDE_W-1:0] orig_pow;
    logic [WIDE_W-1:0] ord_pow;

    bpa_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // Shared arithmetic on the request, the init sweep and the level registers
    assign req_ord    = req_order(req_bytes);
    assign init_k     = init_order(init_idx_reg);
    assign lvl_pow    = WIDE_W'(1) << lvl_reg;
    assign orig_pow   = WIDE_W'(1) << orig_reg;
    assign ord_pow    = WIDE_W'(1) << ord_reg;
    assign half_page  = WIDE_W'(blk_reg) + lvl_pow;
    assign buddy_wide = WIDE_W'(addr_reg) ^ lvl_pow;
    assign cnt_sum    = (WIDE_W + 2)'(count_reg) + (WIDE_W + 2)'(orig_pow);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        ord_next      = ord_reg;
        lvl_next      = lvl_reg;
        orig_next     = orig_reg;
        blk_next      = blk_reg;
        addr_next     = addr_reg;
        buddy_next    = buddy_reg;
        bword_next    = bword_reg;
        pword_next    = pword_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        count_next    = count_reg;
        init_idx_next = init_idx_reg;
        head_nx_next  = head_nx_reg;
        list_head_next = list_head_reg;
        done_next     = 1'b0;
        page_out_next = page_out_reg;
        status_next   = status_reg;
        wr            = '0;
        rd            = '0;

        case (state_reg)
            S_INIT:
            begin
                wr.we   = 1'b1;
                wr.addr = init_idx_reg;
                if (WIDE_W'(init_idx_reg) == head_nx_reg)
                begin
                    wr.data = '{order: init_k, is_free: 1'b1, link: list_head_reg[init_k]};
                    list_head_next[init_k] = LINK_W'(init_idx_reg);
                    head_nx_next = head_nx_reg + (WIDE_W'(1) << init_k);
                end
                else
                begin
                    wr.data = '{order: '0, is_free: 1'b0, link: NIL_LINK};
                end
                if (LINK_W'(init_idx_reg) == LINK_W'(POOL_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_idx_next = init_idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_ALLOC)
                    begin
                        if (req_ord >= ORDC_W'(NUM_ORDERS))
                        begin
                            done_next     = 1'b1;
                            page_out_next = '0;
                            status_next   = ST_FAIL;
                        end
                        else
                        begin
                            ord_next   = ORD_W'(req_ord);
                            lvl_next   = ORD_W'(req_ord);
                            state_next = S_ASRCH;
                        end
                    end
                    else if (WIDE_W'(page_in) >= WIDE_W'(POOL_PAGES))
                    begin
                        done_next     = 1'b1;
                        page_out_next = '0;
                        status_next   = ST_OK;
                    end
                    else
                    begin
                        addr_next  = page_in;
                        rd.re      = 1'b1;
                        rd.addr    = page_in;
                        state_next = S_FCHK;
                    end
                end
            end

            // Look for the first non-empty list, one level a cycle
            S_ASRCH:
            begin
                if (list_head_reg[lvl_reg] != NIL_LINK)
                begin
                    blk_next   = PAGE_W'(list_head_reg[lvl_reg]);
                    rd.re      = 1'b1;
                    rd.addr    = PAGE_W'(list_head_reg[lvl_reg]);
                    state_next = S_APOP;
                end
                else if (lvl_reg == TOP_ORDER)
                begin
                    done_next     = 1'b1;
                    page_out_next = '0;
                    status_next   = ST_FAIL;
                    state_next    = S_IDLE;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end

            S_APOP:
            begin
                list_head_next[lvl_reg] = rd_data.link;
                if (lvl_reg == ord_reg)
                begin
                    state_next = S_AFIN;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_ASPLIT;
                end
            end

            // Push the upper half at the current level when it lies inside the pool
            S_ASPLIT:
            begin
                if (half_page < WIDE_W'(POOL_PAGES))
                begin
                    wr.we   = 1'b1;
                    wr.addr = PAGE_W'(half_page);
                    wr.data = '{order: lvl_reg, is_free: 1'b1, link: list_head_reg[lvl_reg]};
                    list_head_next[lvl_reg] = LINK_W'(half_page);
                end
                if (lvl_reg == ord_reg)
                begin
                    state_next = S_AFIN;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end

            S_AFIN:
            begin
                wr.we   = 1'b1;
                wr.addr = blk_reg;
                wr.data = '{order: ord_reg, is_free: 1'b0, link: NIL_LINK};
                if (WIDE_W'(count_reg) >= ord_pow)
                begin
                    count_next = LINK_W'(WIDE_W'(count_reg) - ord_pow);
                end
                else
                begin
                    count_next = '0;
                end
                done_next     = 1'b1;
                page_out_next = blk_reg;
                status_next   = ST_OK;
                state_next    = S_IDLE;
            end

            S_FCHK:
            begin
                if (rd_data.is_free)
                begin
                    done_next     = 1'b1;
                    page_out_next = '0;
                    status_next   = ST_OK;
                    state_next    = S_IDLE;
                end
                else
                begin
                    if (rd_data.order > TOP_ORDER)
                    begin
                        orig_next = TOP_ORDER;
                        lvl_next  = TOP_ORDER;
                    end
                    else
                    begin
                        orig_next = rd_data.order;
                        lvl_next  = rd_data.order;
                    end
                    state_next = S_FBUD;
                end
            end

            // Fetch the buddy at the current level, or push at the top order or past the pool edge
            S_FBUD:
            begin
                if (lvl_reg < TOP_ORDER && buddy_wide < WIDE_W'(POOL_PAGES))
                begin
                    buddy_next = PAGE_W'(buddy_wide);
                    rd.re      = 1'b1;
                    rd.addr    = PAGE_W'(buddy_wide);
                    state_next = S_FBCHK;
                end
                else
                begin
                    state_next = S_FPUSH;
                end
            end

            S_FBCHK:
            begin
                if (rd_data.is_free && rd_data.order == lvl_reg)
                begin
                    bword_next = rd_data;
                    cur_next   = list_head_reg[lvl_reg];
                    prev_next  = NIL_LINK;
                    steps_next = '0;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_FPUSH;
                end
            end

            // Walk the list to unlink the buddy
            S_WALK:
            begin
                if (cur_reg < LINK_W'(POOL_PAGES) && steps_reg <= WIDE_W'(POOL_PAGES))
                begin
                    rd.re      = 1'b1;
                    rd.addr    = PAGE_W'(cur_reg);
                    state_next = S_WCHK;
                end
                else
                begin
                    wr.we      = 1'b1;
                    wr.addr    = buddy_reg;
                    wr.data    = '{order: bword_reg.order, is_free: 1'b0,
                                   link: bword_reg.link};
                    addr_next  = addr_reg & ~PAGE_W'(lvl_pow);
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_FBUD;
                end
            end

            S_WCHK:
            begin
                if (cur_reg == LINK_W'(buddy_reg))
                begin
                    if (prev_reg == NIL_LINK)
                    begin
                        list_head_next[lvl_reg] = rd_data.link;
                    end
                    else
                    begin
                        wr.we   = 1'b1;
                        wr.addr = PAGE_W'(prev_reg);
                        wr.data = '{order: pword_reg.order, is_free: pword_reg.is_free,
                                    link: rd_data.link};
                    end
                    state_next = S_UNL;
                end
                else
                begin
                    prev_next  = cur_reg;
                    pword_next = rd_data;
                    cur_next   = rd_data.link;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WALK;
                end
            end

            // Clear the buddy and merge up one level
            S_UNL:
            begin
                wr.we      = 1'b1;
                wr.addr    = buddy_reg;
                wr.data    = '{order: bword_reg.order, is_free: 1'b0, link: NIL_LINK};
                addr_next  = addr_reg & ~PAGE_W'(lvl_pow);
                lvl_next   = lvl_reg + 1'b1;
                state_next = S_FBUD;
            end

            S_FPUSH:
            begin
                wr.we   = 1'b1;
                wr.addr = addr_reg;
                wr.data = '{order: lvl_reg, is_free: 1'b1, link: list_head_reg[lvl_reg]};
                list_head_next[lvl_reg] = LINK_W'(addr_reg);
                if (cnt_sum > (WIDE_W + 2)'(POOL_PAGES))
                begin
                    count_next = LINK_W'(POOL_PAGES);
                end
                else
                begin
                    count_next = LINK_W'(cnt_sum);
                end
                done_next     = 1'b1;
                page_out_next = '0;
                status_next   = ST_OK;
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_idx_reg <= '0;
            head_nx_reg  <= '0;
            count_reg    <= LINK_W'(POOL_PAGES);
            done_reg     <= 1'b0;
            for (int k = 0; k < NUM_ORDERS; k++)
            begin
                list_head_reg[k] <= NIL_LINK;
            end
        end
        else
        begin
            state_reg     <= state_next;
            init_idx_reg  <= init_idx_next;
            head_nx_reg   <= head_nx_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            list_head_reg <= list_head_next;
        end
    end

    // Working registers, no reset
    always_ff @(posedge clk)
    begin
        ord_reg      <= ord_next;
        lvl_reg      <= lvl_next;
        orig_reg     <= orig_next;
        blk_reg      <= blk_next;
        addr_reg     <= addr_next;
        buddy_reg    <= buddy_next;
        bword_reg    <= bword_next;
        pword_reg    <= pword_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        steps_reg    <= steps_next;
        page_out_reg <= page_out_next;
        status_reg   <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign page_out   = page_out_reg;
    assign status     = status_reg;
    assign free_pages = count_reg;

    // Checks
    `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done)
    `BPA_ASSERT_SAME(a_fail_zero_page, done && status == ST_FAIL, page_out == '0)
    `BPA_ASSERT_SAME(a_count_bound, done, free_pages <= LINK_W'(POOL_PAGES))
    `BPA_ASSERT_SAME(a_port_excl, wr.we, !rd.re)

endmodule

FILE: bench/tb_buddy_page_allocator.sv
// Testbench for the buddy page allocator: directed table, then random alloc/free traffic.
module tb_buddy_page_allocator
    import bpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS   = 800;
    localparam int QUIET_WORDS    = 150;
    localparam int DRAIN_CYCLES   = 50;
    localparam int NIL            = POOL_PAGES;

    typedef struct {
        logic [PAGE_W-1:0] page;
        logic              st;
        logic [LINK_W-1:0] fpages;
    } alloc_result_t;

    typedef struct {
        logic              op;
        logic [REQ_W-1:0]  bytes;
        logic [PAGE_W-1:0] page;
        bit                typed;
        alloc_result_t     res;
    } table_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              cmd;
    logic [REQ_W-1:0]  req_bytes;
    logic [PAGE_W-1:0] page_in;
    logic              done;
    logic [PAGE_W-1:0] page_out;
    logic              status;
    logic [LINK_W-1:0] free_pages;

    // shadow allocator state
    int  shadow_order [POOL_PAGES];
    bit  shadow_free  [POOL_PAGES];
    int  shadow_link  [POOL_PAGES];
    int  shadow_head  [NUM_ORDERS];
    int  shadow_count;

    alloc_result_t pending_results[$];
    int            live_pages[$];

    // typed expectation travelling with the word being offered
    bit            offer_typed;
    alloc_result_t offer_res;

    int errors;
    int idle_cycles;
    int n_alloc, n_free, n_fail, n_checked;

    buddy_page_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .req_bytes  (req_bytes),
        .page_in    (page_in),
        .done       (done),
        .page_out   (page_out),
        .status     (status),
        .free_pages (free_pages)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void shadow_push(int pg, int ord);
        if (pg >= POOL_PAGES || ord >= NUM_ORDERS)
            return;
        shadow_link[pg]  = shadow_head[ord];
        shadow_head[ord] = pg;
        shadow_free[pg]  = 1'b1;
        shadow_order[pg] = ord;
    endfunction

    // remove pg from the order list, walk bounded against loops
    function automatic void shadow_unlink(int pg, int ord);
        int prev;
        int cur;
        int steps;
        prev  = NIL;
        cur   = shadow_head[ord];
        steps = 0;
        while (cur < POOL_PAGES && steps <= POOL_PAGES)
        begin
            if (cur == pg)
            begin
                if (prev == NIL)
                    shadow_head[ord] = shadow_link[cur];
                else
                    shadow_link[prev] = shadow_link[cur];
                shadow_link[cur] = NIL;
                return;
            end
            prev = cur;
            cur  = shadow_link[cur];
            steps++;
        end
    endfunction

    function automatic void shadow_reset();
        int a;
        int k;
        for (int i = 0; i < POOL_PAGES; i++)
        begin
            shadow_order[i] = 0;
            shadow_free[i]  = 1'b0;
            shadow_link[i]  = NIL;
        end
        for (int i = 0; i < NUM_ORDERS; i++)
            shadow_head[i] = NIL;
        a = 0;
        while (a < POOL_PAGES)
        begin
            k = NUM_ORDERS - 1;
            while (k > 0 && ((a % (1 << k)) != 0 || a + (1 << k) > POOL_PAGES))
                k--;
            shadow_push(a, k);
            a += 1 << k;
        end
        shadow_count = POOL_PAGES;
    endfunction

    // next allocator result for one accepted command word
    function automatic alloc_result_t allocate_or_free(logic op, logic [REQ_W-1:0] bytes,
                                                       logic [PAGE_W-1:0] pg_in);
        alloc_result_t r;
        int ord;
        int i;
        int blk;
        int orig;
        int cur;
        int addr;
        int bud;
        bit found;
        r.page = '0;
        r.st   = ST_OK;
        if (op == CMD_ALLOC)
        begin
            ord = 0;
            while (ord < NUM_ORDERS && ((64'(PAGE_BYTES) << ord) < 64'(bytes)))
                ord++;
            found = 1'b0;
            for (i = ord; i < NUM_ORDERS && !found; i++)
            begin
                blk = shadow_head[i];
                if (blk < POOL_PAGES)
                begin
                    found = 1'b1;
                    shadow_head[i]   = shadow_link[blk];
                    shadow_link[blk] = NIL;
                    for (int j = i - 1; j >= ord; j--)
                        shadow_push(blk + (1 << j), j);
                    shadow_free[blk]  = 1'b0;
                    shadow_order[blk] = ord;
                    if (shadow_count >= (1 << ord))
                        shadow_count -= 1 << ord;
                    else
                        shadow_count = 0;
                    r.page = PAGE_W'(blk);
                end
            end
            if (!found)
                r.st = ST_FAIL;
        end
        else if (!shadow_free[pg_in])
        begin
            orig = shadow_order[pg_in];
            cur  = orig;
            addr = pg_in;
            while (cur < NUM_ORDERS - 1)
            begin
                bud = addr ^ (1 << cur);
                if (bud < POOL_PAGES && shadow_free[bud] && shadow_order[bud] == cur)
                begin
                    shadow_unlink(bud, cur);
                    shadow_free[bud] = 1'b0;
                    addr &= ~(1 << cur);
                    cur++;
                end
                else
                    break;
            end
            shadow_push(addr, cur);
            shadow_count += 1 << orig;
            if (shadow_count > POOL_PAGES)
                shadow_count = POOL_PAGES;
        end
        r.fpages = LINK_W'(shadow_count);
        return r;
    endfunction

    // check the done word, then log an accepted command
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected (page %0d st %0d free %0d)",
                             $realtime, page_out, status, free_pages);
                    errors++;
                end
                else
                begin
                    alloc_result_t e;
                    e = pending_results.pop_front();
                    n_checked++;
                    if (page_out !== e.page)
                    begin
                        $display("%0t: page_out expected %0d actual %0d",
                                 $realtime, e.page, page_out);
                        errors++;
                    end
                    if (status !== e.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, e.st, status);
                        errors++;
                    end
                    if (free_pages !== e.fpages)
                    begin
                        $display("%0t: free_pages expected %0d actual %0d",
                                 $realtime, e.fpages, free_pages);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                alloc_result_t r;
                r = allocate_or_free(cmd, req_bytes, page_in);
                if (cmd == CMD_ALLOC)
                begin
                    n_alloc++;
                    if (r.st == ST_FAIL)
                        n_fail++;
                    else
                        live_pages.push_back(r.page);
                end
                else
                    n_free++;
                pending_results.push_back(offer_typed ? offer_res : r);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $realtime);
            $display("buddy_page_allocator verification failed");
            $finish;
        end
    end

    // offer one word at the falling edge and hold until accepted
    task automatic offer_word(logic op, logic [REQ_W-1:0] bytes, logic [PAGE_W-1:0] pg,
                              bit typed, alloc_result_t res);
        cmd         <= op;
        req_bytes   <= bytes;
        page_in     <= pg;
        offer_typed <= typed;
        offer_res   <= res;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic maybe_gap(bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
    endtask

    table_row_t script[$];

    function automatic table_row_t row(logic op, logic [REQ_W-1:0] bytes,
                                       logic [PAGE_W-1:0] pg, bit typed,
                                       logic [PAGE_W-1:0] e_pg, logic e_st, int e_free);
        table_row_t t;
        t.op         = op;
        t.bytes      = bytes;
        t.page       = pg;
        t.typed      = typed;
        t.res.page   = e_pg;
        t.res.st     = e_st;
        t.res.fpages = LINK_W'(e_free);
        return t;
    endfunction

    initial
    begin
        logic              op;
        logic [REQ_W-1:0]  bytes;
        logic [PAGE_W-1:0] pg;
        int                o;
        int                pick;
        alloc_result_t     none;

        errors      = 0;
        idle_cycles = 0;
        n_alloc     = 0;
        n_free      = 0;
        n_fail      = 0;
        n_checked   = 0;
        none        = '{default: '0};
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_ALLOC;
        req_bytes   = '0;
        page_in     = '0;
        offer_typed = 1'b0;
        offer_res   = none;
        shadow_reset();

        // zero size, oversize, double free, full merge, whole pool, no block
        script.push_back(row(CMD_ALLOC, 24'd0,        10'd0,   1, 10'd0, ST_OK,   1023));
        script.push_back(row(CMD_ALLOC, 24'hFFFFFF,   10'd0,   1, 10'd0, ST_FAIL, 1023));
        script.push_back(row(CMD_FREE,  24'hFFFFFF,   10'd1,   1, 10'd0, ST_OK,   1023));
        script.push_back(row(CMD_FREE,  24'd0,        10'd0,   1, 10'd0, ST_OK,   1024));
        script.push_back(row(CMD_ALLOC, 24'd4194305,  10'd0,   1, 10'd0, ST_FAIL, 1024));
        script.push_back(row(CMD_ALLOC, 24'd4194304,  10'd0,   1, 10'd0, ST_OK,   0));
        script.push_back(row(CMD_ALLOC, 24'd1,        10'd0,   1, 10'd0, ST_FAIL, 0));
        // free of a non-head page, then saturation of the free count
        script.push_back(row(CMD_FREE,  24'd0,        10'd5,   0, 10'd0, ST_OK,   0));
        script.push_back(row(CMD_FREE,  24'd0,        10'd0,   0, 10'd0, ST_OK,   0));
        script.push_back(row(CMD_ALLOC, 24'd4096,     10'd0,   0, 10'd0, ST_OK,   0));
        script.push_back(row(CMD_ALLOC, 24'd4097,     10'd0,   0, 10'd0, ST_OK,   0));
        script.push_back(row(CMD_ALLOC, 24'd8192,     10'd0,   0, 10'd0, ST_OK,   0));
        script.push_back(row(CMD_ALLOC, 24'd2097152,  10'd0,   0, 10'd0, ST_OK,   0));
        script.push_back(row(CMD_ALLOC, 24'd1048577,  10'd0,   0, 10'd0, ST_OK,   0));
        script.push_back(row(CMD_FREE,  24'd0,        10'd1023, 0, 10'd0, ST_OK,  0));
        script.push_back(row(CMD_FREE,  24'd0,        10'd512, 0, 10'd0, ST_OK,   0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (script[i])
        begin
            offer_word(script[i].op, script[i].bytes, script[i].page,
                       script[i].typed, script[i].res);
            maybe_gap(1'b1);
        end

        // random traffic, mostly legal alloc/free pairs
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                op    = CMD_ALLOC;
                bytes = REQ_W'($urandom);
                pg    = PAGE_W'($urandom);
            end
            else if (pick < 10)
            begin
                op    = CMD_FREE;
                bytes = REQ_W'($urandom);
                pg    = PAGE_W'($urandom);
            end
            else if (pick < 50 && live_pages.size() > 0)
            begin
                o     = $urandom_range(0, live_pages.size() - 1);
                op    = CMD_FREE;
                pg    = PAGE_W'(live_pages[o]);
                bytes = REQ_W'($urandom);
                live_pages.delete(o);
            end
            else
            begin
                o     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10)
                                                    : $urandom_range(0, 3);
                op    = CMD_ALLOC;
                pg    = PAGE_W'($urandom);
                bytes = (o == 0) ? REQ_W'($urandom_range(0, PAGE_BYTES))
                                 : REQ_W'($urandom_range((PAGE_BYTES << (o - 1)) + 1,
                                                         PAGE_BYTES << o));
            end
            offer_word(op, bytes, pg, 1'b0, none);
            maybe_gap(n < RANDOM_WORDS - QUIET_WORDS);
        end
        start <= 1'b0;

        // drain
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() > 0)
            errors++;

        $display("Covered %0d allocs (%0d refused) and %0d frees, %0d result words checked.",
                 n_alloc, n_fail, n_free, n_checked);
        if (errors == 0)
            $display("buddy_page_allocator verification clean");
        else
            $display("buddy_page_allocator verification failed");
        $finish;
    end

endmodule

FILE: buddy_page_allocator.f
+incdir+src
src/bpa_pkg.sv
src/bpa_mem.sv
src/buddy_page_allocator.sv
bench/tb_buddy_page_allocator.sv
